/* rtl/fva_pkg.sv */
// Shared types, codes and the arctangent table for the force vector accumulator.
// No dependencies; imported by every module of the block.
package fva_pkg;

    localparam int FORCE_W        = 32;   // port width of force fields
    localparam int LEVEL_W        = 31;   // saturation level register
    localparam int HEADING_W      = 16;   // Q3.13 heading
    localparam int ANGLE_W        = 18;   // internal angle accumulator
    localparam int MUL_W          = 32;   // squaring multiplier operand
    localparam int STEP_IDX_W     = 5;    // covers up to 32 iterations
    localparam int DEF_CORDIC_STEPS    = 16;
    localparam int DEF_COMPONENT_WIDTH = 32;

    localparam logic signed [ANGLE_W-1:0] HEADING_PI = ANGLE_W'(25736);

    // input modes
    localparam logic [1:0] MODE_SET_X = 2'd0;
    localparam logic [1:0] MODE_ADD_X = 2'd1;
    localparam logic [1:0] MODE_SET_Y = 2'd2;
    localparam logic [1:0] MODE_ADD_Y = 2'd3;

    // squaring operand select
    localparam logic [1:0] SQ_X   = 2'd0;
    localparam logic [1:0] SQ_Y   = 2'd1;
    localparam logic [1:0] SQ_LIM = 2'd2;

    // accumulate operation on the registered product
    localparam logic [1:0] ACC_NONE = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_LIM  = 2'd3;

    typedef struct packed {
        logic                  load_in;
        logic                  prep;
        logic                  iter;
        logic [STEP_IDX_W-1:0] step;
        logic                  sq_en;
        logic [1:0]            sq_sel;
        logic [1:0]            acc_op;
        logic                  load_out;
    } fva_cmd_t;

    // atan(2^-i) in Q3.13, rounded
    function automatic logic signed [ANGLE_W-1:0] atan_entry(
        input logic [STEP_IDX_W-1:0] idx
    );
        logic signed [ANGLE_W-1:0] val;
        case (idx)
            5'd0:    val = ANGLE_W'(6434);
            5'd1:    val = ANGLE_W'(3798);
            5'd2:    val = ANGLE_W'(2007);
            5'd3:    val = ANGLE_W'(1019);
            5'd4:    val = ANGLE_W'(511);
            5'd5:    val = ANGLE_W'(256);
            5'd6:    val = ANGLE_W'(128);
            5'd7:    val = ANGLE_W'(64);
            5'd8:    val = ANGLE_W'(32);
            5'd9:    val = ANGLE_W'(16);
            5'd10:   val = ANGLE_W'(8);
            5'd11:   val = ANGLE_W'(4);
            5'd12:   val = ANGLE_W'(2);
            5'd13:   val = ANGLE_W'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/fva_ctrl.sv */
// Sequencer for the force vector accumulator: handshakes, CORDIC step count,
// squaring schedule and output register valid. Depends on fva_pkg.
module fva_ctrl import fva_pkg::*; #(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output fva_cmd_t cmd
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PREP   = 2'd1;
    localparam logic [1:0] ST_ITER   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    logic [STEP_IDX_W-1:0] step_idx;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign step_idx = STEP_IDX_W'(step_reg);

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        cmd.step     = step_idx;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = ST_ITER;
            end
            ST_ITER: begin
                cmd.iter = 1'b1;
                // squares run beside the first iterations
                case (step_idx)
                    5'd0: begin
                        cmd.sq_en  = 1'b1;
                        cmd.sq_sel = SQ_X;
                    end
                    5'd1: begin
                        cmd.sq_en  = 1'b1;
                        cmd.sq_sel = SQ_Y;
                        cmd.acc_op = ACC_LOAD;
                    end
                    5'd2: begin
                        cmd.sq_en  = 1'b1;
                        cmd.sq_sel = SQ_LIM;
                        cmd.acc_op = ACC_ADD;
                    end
                    5'd3: begin
                        cmd.acc_op = ACC_LIM;
                    end
                    default: begin
                        cmd.acc_op = ACC_NONE;
                    end
                endcase
                if (step_reg == LAST_STEP) begin
                    state_next = ST_FINISH;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* rtl/fva_datapath.sv */
// Datapath: component registers with saturating update, shared squaring
// multiplier, CORDIC vectoring unit and result register. Depends on fva_pkg.
module fva_datapath import fva_pkg::*; #(
    parameter int COMPONENT_WIDTH = DEF_COMPONENT_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  fva_cmd_t                    cmd,
    input  logic [1:0]                  s_mode,
    input  logic signed [FORCE_W-1:0]   s_value,
    input  logic                        cfg_we,
    input  logic [LEVEL_W-1:0]          cfg_data,
    output logic signed [FORCE_W-1:0]   m_force_x,
    output logic signed [FORCE_W-1:0]   m_force_y,
    output logic signed [HEADING_W-1:0] m_heading,
    output logic                        m_is_saturated
);

    localparam int CW  = COMPONENT_WIDTH;
    localparam int SW  = FORCE_W + 1;     // update sum width
    localparam int CXW = CW + 3;          // CORDIC x/y width, covers gain
    localparam int PW  = 2 * MUL_W;
    localparam int LW  = 2 * LEVEL_W;

    localparam logic signed [SW-1:0] COMP_HI = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] COMP_LO = -COMP_HI - SW'(1);

    logic signed [CW-1:0]      x_comp_reg, y_comp_reg;
    logic [LEVEL_W-1:0]        level_reg;
    logic signed [CXW-1:0]     cx_reg, cy_reg;
    logic signed [ANGLE_W-1:0] cz_reg;
    logic                      zero_reg;
    logic [PW-1:0]             prod_reg;
    logic [PW-1:0]             sumsq_reg;
    logic [LW-1:0]             lim2_reg;

    logic signed [FORCE_W-1:0]   out_x_reg, out_y_reg;
    logic signed [HEADING_W-1:0] out_h_reg;
    logic                        out_sat_reg;

    // component update
    logic signed [SW-1:0] upd_base, upd_sum, upd_clamped;
    logic                 upd_is_y;

    always_comb begin
        upd_is_y = (s_mode == MODE_SET_Y) || (s_mode == MODE_ADD_Y);
        case (s_mode)
            MODE_ADD_X: upd_base = SW'(x_comp_reg);
            MODE_ADD_Y: upd_base = SW'(y_comp_reg);
            default:    upd_base = '0;
        endcase
        upd_sum = upd_base + SW'(s_value);
        if (upd_sum > COMP_HI) begin
            upd_clamped = COMP_HI;
        end else if (upd_sum < COMP_LO) begin
            upd_clamped = COMP_LO;
        end else begin
            upd_clamped = upd_sum;
        end
    end

    // magnitudes for squaring
    logic signed [CW:0] x_ext, y_ext, x_abs, y_abs;
    logic [MUL_W-1:0]   sq_opnd;

    always_comb begin
        x_ext = (CW + 1)'(x_comp_reg);
        y_ext = (CW + 1)'(y_comp_reg);
        x_abs = x_comp_reg[CW-1] ? -x_ext : x_ext;
        y_abs = y_comp_reg[CW-1] ? -y_ext : y_ext;
        case (cmd.sq_sel)
            SQ_X:    sq_opnd = MUL_W'(x_abs[CW-1:0]);
            SQ_Y:    sq_opnd = MUL_W'(y_abs[CW-1:0]);
            SQ_LIM:  sq_opnd = MUL_W'(level_reg);
            default: sq_opnd = '0;
        endcase
    end

    // CORDIC step
    logic signed [CXW-1:0]     cx_shift, cy_shift;
    logic signed [ANGLE_W-1:0] angle;
    logic signed [CXW-1:0]     cx_init, cy_init;

    always_comb begin
        cx_shift = cx_reg >>> cmd.step;
        cy_shift = cy_reg >>> cmd.step;
        angle    = atan_entry(cmd.step);
        cx_init  = CXW'(x_comp_reg);
        cy_init  = CXW'(y_comp_reg);
    end

    // clamped heading
    logic signed [ANGLE_W-1:0] z_clamped;

    always_comb begin
        if (cz_reg > HEADING_PI) begin
            z_clamped = HEADING_PI;
        end else if (cz_reg < -HEADING_PI) begin
            z_clamped = -HEADING_PI;
        end else begin
            z_clamped = cz_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_comp_reg <= '0;
            y_comp_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (cfg_we) begin
                level_reg <= cfg_data;
            end
            if (cmd.load_in) begin
                if (upd_is_y) begin
                    y_comp_reg <= upd_clamped[CW-1:0];
                end else begin
                    x_comp_reg <= upd_clamped[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            zero_reg <= (x_comp_reg == '0) && (y_comp_reg == '0);
            if (x_comp_reg[CW-1]) begin
                cx_reg <= -cx_init;
                cy_reg <= -cy_init;
                cz_reg <= y_comp_reg[CW-1] ? -HEADING_PI : HEADING_PI;
            end else begin
                cx_reg <= cx_init;
                cy_reg <= cy_init;
                cz_reg <= '0;
            end
        end else if (cmd.iter) begin
            if (cy_reg[CXW-1]) begin
                cx_reg <= cx_reg - cy_shift;
                cy_reg <= cy_reg + cx_shift;
                cz_reg <= cz_reg - angle;
            end else begin
                cx_reg <= cx_reg + cy_shift;
                cy_reg <= cy_reg - cx_shift;
                cz_reg <= cz_reg + angle;
            end
        end

        if (cmd.sq_en) begin
            prod_reg <= sq_opnd * sq_opnd;
        end
        case (cmd.acc_op)
            ACC_LOAD: sumsq_reg <= prod_reg;
            ACC_ADD:  sumsq_reg <= sumsq_reg + prod_reg;
            ACC_LIM:  lim2_reg  <= prod_reg[LW-1:0];
            default:  sumsq_reg <= sumsq_reg;
        endcase

        if (cmd.load_out) begin
            out_x_reg   <= FORCE_W'(x_comp_reg);
            out_y_reg   <= FORCE_W'(y_comp_reg);
            out_h_reg   <= zero_reg ? '0 : z_clamped[HEADING_W-1:0];
            out_sat_reg <= (sumsq_reg >= PW'(lim2_reg));
        end
    end

    assign m_force_x      = out_x_reg;
    assign m_force_y      = out_y_reg;
    assign m_heading      = out_h_reg;
    assign m_is_saturated = out_sat_reg;

endmodule

/* rtl/force_vector_accumulator_unit.sv */
// Top level of the force vector accumulator: sequencer plus datapath.
// Depends on fva_pkg, fva_ctrl and fva_datapath.
//
// Keeps a 2-D force vector in signed Q16.16. Each item sets or adds to X or
// Y (saturating at the component limits) and yields one result with both
// components, the heading atan2(y,x) in Q3.13 radians (zero for the zero
// vector) and a flag that is set when x*x + y*y >= saturation_level^2.
// From acceptance until the next item can be accepted, an item passes
// through an accept state, a pre-rotation state, one CORDIC iteration per
// step and a finish state that loads the result register. The squares for
// the flag go through a single 32x32 multiplier during the first CORDIC
// iterations. The result register lets the next item enter while a result
// still waits on m_ready; a result that is not yet taken when the next one
// is ready holds the block.
// cfg_data may be written at any idle time and takes effect on the next item.
module force_vector_accumulator_unit import fva_pkg::*; #(
    parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
    parameter int COMPONENT_WIDTH = DEF_COMPONENT_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_mode,
    input  logic signed [FORCE_W-1:0]   s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [FORCE_W-1:0]   m_force_x,
    output logic signed [FORCE_W-1:0]   m_force_y,
    output logic signed [HEADING_W-1:0] m_heading,
    output logic                        m_is_saturated,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [LEVEL_W-1:0]          cfg_data
);

    fva_cmd_t cmd;

    assign cfg_ready = 1'b1;

    fva_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    fva_datapath #(
        .COMPONENT_WIDTH(COMPONENT_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_mode         (s_mode),
        .s_value        (s_value),
        .cfg_we         (cfg_valid & cfg_ready),
        .cfg_data       (cfg_data),
        .m_force_x      (m_force_x),
        .m_force_y      (m_force_y),
        .m_heading      (m_heading),
        .m_is_saturated (m_is_saturated)
    );

endmodule
